>>> design/deq_pkg.sv
// Shared constants, operation and fault codes, and ring index helpers
// for the double-ended queue. No dependencies.
package deq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int FAULT_W  = 2;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [FAULT_W-1:0] fault_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam op_t OP_QUERY      = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_PUSH_FRONT = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_POP_FRONT  = 3'd4;

  localparam fault_t FAULT_NONE      = 2'd0;
  localparam fault_t FAULT_UNDERFLOW = 2'd1;
  localparam fault_t FAULT_OVERFLOW  = 2'd2;

  localparam logic signed [DATA_W-1:0] MISSING_VALUE = -32'sd1;

  function automatic idx_t wrap_inc(input idx_t i);
    return (i == idx_t'(CAPACITY - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t wrap_dec(input idx_t i);
    return (i == '0) ? idx_t'(CAPACITY - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

>>> design/double_ended_queue_core.sv
// Top level of the double-ended queue: pointer and count control, entry RAM,
// and the result register. Depends on deq_pkg and deq_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request: an operation
//   code and a signed value. Codes are query, push back, push front, pop back
//   and pop front; codes five to seven act as a query. The result channel
//   (out_valid/out_ready) returns one result per request: the count, an empty
//   flag, the front, back, second-front and second-back values (-1 where the
//   entry does not exist) and a fault code for pop on empty or push on full.
//   A request is handled in steps before the next request can be accepted:
//   the pointers are updated and a pushed value is written, the edge
//   entries are read in turn through the single read port of the entry RAM,
//   and the result register is loaded once the output register is free.
//   Reset clears the pointers and the count; RAM contents are not cleared and
//   need no clearing pass. If the receiver stalls, the result is held in the
//   output register and the next request is still accepted and processed; it
//   waits in the block until the output register is free.
module double_ended_queue_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  deq_pkg::op_t                  in_operation,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [deq_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_is_empty,
  output logic signed [31:0]            out_front_value,
  output logic signed [31:0]            out_back_value,
  output logic signed [31:0]            out_second_front_value,
  output logic signed [31:0]            out_second_back_value,
  output deq_pkg::fault_t               out_fault
);
  import deq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_t;

  state_t            state_r;
  idx_t              front_r, front_nxt;
  idx_t              back_r, back_nxt;
  cnt_t              cnt_r, cnt_nxt;
  fault_t            fault_r, fault_nxt;
  logic [2:0]        rd_idx_r;
  logic [DATA_W-1:0] val_r [4];
  logic              out_valid_r;

  logic              accept;
  logic              full;
  logic              empty;
  logic              we;
  idx_t              waddr;
  idx_t              raddr;
  idx_t              last;
  logic [DATA_W-1:0] rdata;
  logic [1:0]        cap_idx;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (cnt_r >= cnt_t'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign last      = wrap_dec(back_r);
  assign cap_idx   = rd_idx_r[1:0] - 2'd1;

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    cnt_nxt   = cnt_r;
    fault_nxt = FAULT_NONE;
    we        = 1'b0;
    waddr     = back_r;
    unique case (in_operation)
      OP_PUSH_BACK: begin
        if (full) begin
          fault_nxt = FAULT_OVERFLOW;
        end else begin
          we       = accept;
          waddr    = back_r;
          back_nxt = wrap_inc(back_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          fault_nxt = FAULT_OVERFLOW;
        end else begin
          front_nxt = wrap_dec(front_r);
          we        = accept;
          waddr     = front_nxt;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          fault_nxt = FAULT_UNDERFLOW;
        end else begin
          back_nxt = wrap_dec(back_r);
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          fault_nxt = FAULT_UNDERFLOW;
        end else begin
          front_nxt = wrap_inc(front_r);
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (rd_idx_r[1:0])
      2'd0:    raddr = front_r;
      2'd1:    raddr = wrap_inc(front_r);
      2'd2:    raddr = last;
      default: raddr = wrap_dec(last);
    endcase
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            front_r  <= front_nxt;
            back_r   <= back_nxt;
            cnt_r    <= cnt_nxt;
            fault_r  <= fault_nxt;
            rd_idx_r <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          if (rd_idx_r != '0) begin
            val_r[cap_idx] <= rdata;
          end
          if (rd_idx_r == 3'd4) begin
            state_r <= S_DONE;
          end else begin
            rd_idx_r <= rd_idx_r + 3'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_count              <= COUNT_W'(cnt_r);
            out_is_empty           <= (cnt_r == '0);
            out_front_value        <= (cnt_r >= cnt_t'(1)) ? val_r[0] : MISSING_VALUE;
            out_second_front_value <= (cnt_r >= cnt_t'(2)) ? val_r[1] : MISSING_VALUE;
            out_back_value         <= (cnt_r >= cnt_t'(1)) ? val_r[2] : MISSING_VALUE;
            out_second_back_value  <= (cnt_r >= cnt_t'(2)) ? val_r[3] : MISSING_VALUE;
            out_fault              <= fault_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/deq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
